[design/mpr_pkg.sv]
// Shared types and constants for the Modbus PDU responder.
package mpr_pkg;

  // Stream widths
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 48;

  // Function codes served
  localparam logic [7:0] FcReadCoils    = 8'h01;
  localparam logic [7:0] FcReadHolding  = 8'h03;
  localparam logic [7:0] FcReadInput    = 8'h04;
  localparam logic [7:0] FcWriteCoil    = 8'h05;
  localparam logic [7:0] FcWriteReg     = 8'h06;

  // Exception codes and flag
  localparam logic [7:0] ExcFlag        = 8'h80;
  localparam logic [7:0] ExcIllegalFunc = 8'h01;
  localparam logic [7:0] ExcIllegalAddr = 8'h02;
  localparam logic [7:0] ExcIllegalVal  = 8'h03;

  // Table sizes and limits
  localparam logic [16:0] NumCoils     = 17'd2;
  localparam logic [16:0] NumRegs      = 17'd4;
  localparam logic [15:0] CoilOn       = 16'hFF00;
  localparam logic [15:0] LimitMax     = 16'd1000;
  localparam logic [7:0]  MinReqLen    = 8'd5;
  localparam logic [9:0]  RateReset    = 10'd100;

  // Response lengths in bytes
  localparam logic [3:0]  LenExc   = 4'd2;
  localparam logic [3:0]  LenCoils = 4'd3;
  localparam logic [3:0]  LenEcho  = 4'd5;

  // Kind of response being sent
  typedef enum logic [2:0] {
    RK_NONE,
    RK_EXC,
    RK_COILS,
    RK_REGS,
    RK_ECHO
  } resp_kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the request transaction
    logic eval;      // decode request, update holding registers
    logic advance;   // step to the next response byte
  } mpr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;     // request yields no response
    logic last;      // current byte is the final one
  } mpr_status_t;

endpackage

[design/modbus_pdu_responder.sv]
// Top level of the Modbus PDU responder.
// Each input transaction is one decoded request PDU with live status; the block
// answers with the response PDU one byte per output transaction, tlast on the
// final byte. A request is captured, then decoded, then its response bytes are
// sent: 2 bytes for an exception, 3 for read coils, 4 to 10 for register reads,
// 5 for write echoes; a zero-length request gives no output. One request is
// handled at a time: the input is ready only once the last byte of the previous
// response is taken. Holding registers reset to direction 0, speed 0, accel 100,
// decel 100, and their current values ride on every output byte.
module modbus_pdu_responder
  import mpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // function_code[7:0], start_address[23:8], quantity_or_value[39:24],
  // request_length[47:40], wifi_connected[48], motor_enabled[49],
  // direction_forward[50], rail_voltage_mv[66:51], current_speed[82:67],
  // uptime_seconds[98:83], zero pad[103:99]
  input  logic [InDataW-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // resp_byte[7:0], enable_strobe[8], enable_value[9], estop_strobe[10],
  // direction_reverse[11], speed_setpoint[21:12], accel_rate[31:22],
  // decel_rate[41:32], zero pad[47:42]
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast
);

  mpr_cmd_t    cmd;
  mpr_status_t status;

  mpr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mpr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

[design/mpr_ctrl.sv]
// Controller state machine for the Modbus PDU responder.
module mpr_ctrl
  import mpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  mpr_status_t status,
  output mpr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = status.empty ? ST_IDLE : ST_SEND;
      ST_SEND: if (out_tready && status.last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Handshakes and commands; refuse input while reset is held
  assign in_tready   = (state_r == ST_IDLE) && rst_n;
  assign out_tvalid  = (state_r == ST_SEND);
  assign cmd.capture = in_tready && in_tvalid;
  assign cmd.eval    = (state_r == ST_EVAL);
  assign cmd.advance = out_tvalid && out_tready;

endmodule

[design/mpr_datapath.sv]
// Request decode, holding registers and response byte generation.
module mpr_datapath
  import mpr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  mpr_cmd_t            cmd,
  input  logic [InDataW-1:0]  in_tdata,
  output mpr_status_t         status,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast
);

  // Latched request
  logic [7:0]  fc_r;
  logic [15:0] addr_r;
  logic [15:0] qv_r;
  logic [7:0]  len_in_r;
  logic [15:0] ireg_r [4];

  // Decoded response
  resp_kind_t  kind_r, kind_nxt;
  logic [7:0]  exc_r, exc_nxt;
  logic [3:0]  rlen_r, rlen_nxt;
  logic        en_stb_r, en_stb_nxt;
  logic        en_val_r, en_val_nxt;
  logic        estop_r, estop_nxt;
  logic        wr_en;
  logic [3:0]  idx_r;

  // Holding registers
  logic        hold_dir_r;
  logic [9:0]  hold_speed_r;
  logic [9:0]  hold_accel_r;
  logic [9:0]  hold_decel_r;

  logic [16:0] sum;
  logic        known;
  logic        bad_val;
  logic        coil_bit;
  logic [1:0]  word_sel;
  logic [1:0]  reg_idx;
  logic [15:0] word;
  logic [7:0]  resp_byte;
  logic        last;

  // Capture the request transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fc_r      <= in_tdata[7:0];
      addr_r    <= in_tdata[23:8];
      qv_r      <= in_tdata[39:24];
      len_in_r  <= in_tdata[47:40];
      ireg_r[0] <= {13'd0, ~in_tdata[50], in_tdata[49], in_tdata[48]};
      ireg_r[1] <= in_tdata[66:51];
      ireg_r[2] <= in_tdata[82:67];
      ireg_r[3] <= in_tdata[98:83];
    end
  end

  // Decode the latched request
  assign sum   = {1'b0, addr_r} + {1'b0, qv_r};
  assign known = (fc_r == FcReadCoils) || (fc_r == FcReadHolding) ||
                 (fc_r == FcReadInput) || (fc_r == FcWriteCoil) ||
                 (fc_r == FcWriteReg);

  always_comb begin
    bad_val = 1'b0;
    priority if (addr_r == 16'd0) begin
      bad_val = (qv_r > 16'd1);
    end else if (addr_r == 16'd1) begin
      bad_val = (qv_r > LimitMax);
    end else begin
      bad_val = (qv_r == 16'd0) || (qv_r > LimitMax);
    end
  end

  always_comb begin
    kind_nxt   = RK_EXC;
    exc_nxt    = ExcIllegalFunc;
    rlen_nxt   = LenExc;
    en_stb_nxt = 1'b0;
    en_val_nxt = 1'b0;
    estop_nxt  = 1'b0;
    wr_en      = 1'b0;
    priority if (len_in_r == 8'd0) begin
      kind_nxt = RK_NONE;
    end else if (!known) begin
      exc_nxt = ExcIllegalFunc;
    end else if (len_in_r < MinReqLen) begin
      exc_nxt = ExcIllegalVal;
    end else if (fc_r == FcReadCoils) begin
      if (qv_r == 16'd0 || sum > NumCoils) begin
        exc_nxt = ExcIllegalAddr;
      end else begin
        kind_nxt = RK_COILS;
        rlen_nxt = LenCoils;
      end
    end else if (fc_r == FcReadHolding || fc_r == FcReadInput) begin
      if (qv_r == 16'd0 || sum > NumRegs) begin
        exc_nxt = ExcIllegalAddr;
      end else begin
        kind_nxt = RK_REGS;
        rlen_nxt = 4'd2 + {qv_r[2:0], 1'b0};
      end
    end else if (fc_r == FcWriteCoil) begin
      if ({1'b0, addr_r} >= NumCoils) begin
        exc_nxt = ExcIllegalAddr;
      end else if (qv_r != CoilOn && qv_r != 16'd0) begin
        exc_nxt = ExcIllegalVal;
      end else begin
        kind_nxt   = RK_ECHO;
        rlen_nxt   = LenEcho;
        en_stb_nxt = (addr_r == 16'd0);
        en_val_nxt = (addr_r == 16'd0) && (qv_r == CoilOn);
        estop_nxt  = (addr_r == 16'd1) && (qv_r == CoilOn);
      end
    end else begin
      if ({1'b0, addr_r} >= NumRegs) begin
        exc_nxt = ExcIllegalAddr;
      end else if (bad_val) begin
        exc_nxt = ExcIllegalVal;
      end else begin
        kind_nxt = RK_ECHO;
        rlen_nxt = LenEcho;
        wr_en    = 1'b1;
      end
    end
  end

  assign status.empty = (kind_nxt == RK_NONE);

  // Hold the decoded response
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= RK_NONE;
      en_stb_r <= 1'b0;
      en_val_r <= 1'b0;
      estop_r  <= 1'b0;
    end else if (cmd.eval) begin
      kind_r   <= kind_nxt;
      en_stb_r <= en_stb_nxt;
      en_val_r <= en_val_nxt;
      estop_r  <= estop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      exc_r  <= exc_nxt;
      rlen_r <= rlen_nxt;
    end
  end

  // Advance the byte index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
    end else if (cmd.eval) begin
      idx_r <= 4'd0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + 4'd1;
    end
  end

  // Write holding registers on an accepted write single register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_dir_r   <= 1'b0;
      hold_speed_r <= 10'd0;
      hold_accel_r <= RateReset;
      hold_decel_r <= RateReset;
    end else if (cmd.eval && wr_en) begin
      unique case (addr_r[1:0])
        2'd0: hold_dir_r   <= qv_r[0];
        2'd1: hold_speed_r <= qv_r[9:0];
        2'd2: hold_accel_r <= qv_r[9:0];
        2'd3: hold_decel_r <= qv_r[9:0];
        default: hold_dir_r <= hold_dir_r;
      endcase
    end
  end

  // Select the register word for a read response (word k sits at bytes 2k+2, 2k+3)
  assign word_sel = idx_r[2:1] - 2'd1;
  assign reg_idx  = addr_r[1:0] + word_sel;

  always_comb begin
    if (fc_r == FcReadHolding) begin
      unique case (reg_idx)
        2'd0: word = {15'd0, hold_dir_r};
        2'd1: word = {6'd0, hold_speed_r};
        2'd2: word = {6'd0, hold_accel_r};
        2'd3: word = {6'd0, hold_decel_r};
        default: word = 16'd0;
      endcase
    end else begin
      word = ireg_r[reg_idx];
    end
  end

  assign coil_bit = (addr_r == 16'd0) && ireg_r[0][1];

  // Build the current response byte
  always_comb begin
    resp_byte = 8'd0;
    unique case (kind_r)
      RK_EXC: begin
        resp_byte = (idx_r == 4'd0) ? (fc_r | ExcFlag) : exc_r;
      end
      RK_COILS: begin
        priority case (idx_r)
          4'd0:    resp_byte = fc_r;
          4'd1:    resp_byte = 8'd1;
          default: resp_byte = {7'd0, coil_bit};
        endcase
      end
      RK_REGS: begin
        priority case (idx_r)
          4'd0:    resp_byte = fc_r;
          4'd1:    resp_byte = {qv_r[6:0], 1'b0};
          default: resp_byte = idx_r[0] ? word[7:0] : word[15:8];
        endcase
      end
      RK_ECHO: begin
        priority case (idx_r)
          4'd0:    resp_byte = fc_r;
          4'd1:    resp_byte = addr_r[15:8];
          4'd2:    resp_byte = addr_r[7:0];
          4'd3:    resp_byte = qv_r[15:8];
          default: resp_byte = qv_r[7:0];
        endcase
      end
      default: resp_byte = 8'd0;
    endcase
  end

  assign last        = (idx_r == rlen_r - 4'd1);
  assign status.last = last;
  assign out_tlast   = last;

  // resp_byte, enable_strobe, enable_value, estop_strobe, direction_reverse,
  // speed_setpoint, accel_rate, decel_rate, zero pad
  assign out_tdata = {6'd0,
                      hold_decel_r,
                      hold_accel_r,
                      hold_speed_r,
                      hold_dir_r,
                      estop_r && last,
                      en_val_r && last,
                      en_stb_r && last,
                      resp_byte};

endmodule

[design/mpr_checker.sv]
// Port-level checks for the Modbus PDU responder, bound to the top level.
module mpr_checker
  import mpr_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tlast
);

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output transaction changed while stalled");

  // No new request while a response is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready during response");

  // An accepted request closes the input for at least the decode cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input ready right after a request transaction");

  // Strobes only on the final byte, enable value only with its strobe
  a_strobe_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[8] || out_tdata[9] || out_tdata[10])) |->
      (out_tlast && (out_tdata[8] || !out_tdata[9])))
    else $error("strobe off the final byte");

  // Holding register outputs stay in their checked ranges
  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[21:12] <= 10'd1000 && out_tdata[31:22] != 10'd0 &&
                    out_tdata[31:22] <= 10'd1000 && out_tdata[41:32] != 10'd0 &&
                    out_tdata[41:32] <= 10'd1000))
    else $error("holding register out of range");

endmodule

bind modbus_pdu_responder mpr_checker u_mpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/sv/testbench.sv]
// Self-checking testbench for the Modbus PDU responder: stimulus, prediction and checking.
`timescale 1ns / 1ps

import mpr_pkg::*;

// One decoded request with its live status
typedef struct packed {
  logic [7:0]  fc;
  logic [15:0] addr;
  logic [15:0] qv;
  logic [7:0]  len;
  logic        wifi;
  logic        en;
  logic        fwd;
  logic [15:0] rail_mv;
  logic [15:0] cur_speed;
  logic [15:0] uptime;
} mb_request_t;

// One response byte with the motor outputs that ride on it
typedef struct {
  logic [7:0] data;
  logic       last;
  logic       en_strobe;
  logic       en_value;
  logic       estop;
  logic       dir;
  logic [9:0] speed;
  logic [9:0] accel;
  logic [9:0] decel;
} mb_byte_t;

class mb_response_board;
  mb_byte_t    expected_q[$];
  logic [15:0] holding[4];
  int          requests;
  int          exceptions;
  int          empties;
  int          bytes_seen;
  int          errors;

  function new();
    holding[0] = 16'd0;
    holding[1] = 16'd0;
    holding[2] = {6'd0, RateReset};
    holding[3] = {6'd0, RateReset};
    requests   = 0;
    exceptions = 0;
    empties    = 0;
    bytes_seen = 0;
    errors     = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Queue one byte, tagged with the holding registers as they stand now
  function void push_byte(logic [7:0] b, logic last, logic ens, logic env, logic es);
    mb_byte_t e;
    e.data      = b;
    e.last      = last;
    e.en_strobe = ens;
    e.en_value  = env;
    e.estop     = es;
    e.dir       = holding[0][0];
    e.speed     = holding[1][9:0];
    e.accel     = holding[2][9:0];
    e.decel     = holding[3][9:0];
    expected_q.push_back(e);
  endfunction

  function void push_exception(logic [7:0] fc, logic [7:0] code);
    exceptions++;
    push_byte(fc | ExcFlag, 1'b0, 1'b0, 1'b0, 1'b0);
    push_byte(code, 1'b1, 1'b0, 1'b0, 1'b0);
  endfunction

  // Echo of a single write; strobes go on the final byte only
  function void push_echo(logic [7:0] fc, logic [15:0] addr, logic [15:0] qv,
                          logic ens, logic env, logic es);
    push_byte(fc, 1'b0, 1'b0, 1'b0, 1'b0);
    push_byte(addr[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
    push_byte(addr[7:0], 1'b0, 1'b0, 1'b0, 1'b0);
    push_byte(qv[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
    push_byte(qv[7:0], 1'b1, ens, env, es);
  endfunction

  // Work out the response bytes of one accepted request transaction
  function void note_request(mb_request_t r);
    logic [16:0] span;
    logic [15:0] iregs[4];
    logic [15:0] word;
    logic [1:0]  idx;
    logic        bad_value;
    int          i;
    span     = {1'b0, r.addr} + {1'b0, r.qv};
    iregs[0] = {13'd0, ~r.fwd, r.en, r.wifi};
    iregs[1] = r.rail_mv;
    iregs[2] = r.cur_speed;
    iregs[3] = r.uptime;
    requests++;
    if (r.len == 8'd0) begin
      empties++;
      return;
    end
    if (!(r.fc inside {FcReadCoils, FcReadHolding, FcReadInput, FcWriteCoil, FcWriteReg})) begin
      push_exception(r.fc, ExcIllegalFunc);
      return;
    end
    if (r.len < MinReqLen) begin
      push_exception(r.fc, ExcIllegalVal);
      return;
    end
    case (r.fc)
      FcReadCoils: begin
        if (r.qv == 16'd0 || span > NumCoils) begin
          push_exception(r.fc, ExcIllegalAddr);
        end else begin
          // Only coil 0 can read as set; the emergency stop coil reads 0
          push_byte(r.fc, 1'b0, 1'b0, 1'b0, 1'b0);
          push_byte(8'd1, 1'b0, 1'b0, 1'b0, 1'b0);
          push_byte({7'd0, r.addr == 16'd0 && r.en}, 1'b1, 1'b0, 1'b0, 1'b0);
        end
      end
      FcReadHolding, FcReadInput: begin
        if (r.qv == 16'd0 || span > NumRegs) begin
          push_exception(r.fc, ExcIllegalAddr);
        end else begin
          push_byte(r.fc, 1'b0, 1'b0, 1'b0, 1'b0);
          push_byte({r.qv[6:0], 1'b0}, 1'b0, 1'b0, 1'b0, 1'b0);
          for (i = 0; i < int'(r.qv); i++) begin
            idx  = r.addr[1:0] + i[1:0];
            word = (r.fc == FcReadHolding) ? holding[idx] : iregs[idx];
            push_byte(word[15:8], 1'b0, 1'b0, 1'b0, 1'b0);
            push_byte(word[7:0], i == int'(r.qv) - 1, 1'b0, 1'b0, 1'b0);
          end
        end
      end
      FcWriteCoil: begin
        if ({1'b0, r.addr} >= NumCoils) begin
          push_exception(r.fc, ExcIllegalAddr);
        end else if (r.qv != CoilOn && r.qv != 16'd0) begin
          push_exception(r.fc, ExcIllegalVal);
        end else begin
          push_echo(r.fc, r.addr, r.qv, r.addr == 16'd0,
                    r.addr == 16'd0 && r.qv == CoilOn,
                    r.addr == 16'd1 && r.qv == CoilOn);
        end
      end
      FcWriteReg: begin
        bad_value = (r.addr == 16'd0 && r.qv > 16'd1) ||
                    (r.addr == 16'd1 && r.qv > LimitMax) ||
                    (r.addr >= 16'd2 && (r.qv == 16'd0 || r.qv > LimitMax));
        if ({1'b0, r.addr} >= NumRegs) begin
          push_exception(r.fc, ExcIllegalAddr);
        end else if (bad_value) begin
          push_exception(r.fc, ExcIllegalVal);
        end else begin
          // Update before the echo so every echo byte carries the new value
          holding[r.addr[1:0]] = r.qv;
          push_echo(r.fc, r.addr, r.qv, 1'b0, 1'b0, 1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  function void compare(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Match one accepted output transaction against the oldest expected byte
  function void check_byte(logic [OutDataW-1:0] d, logic last);
    mb_byte_t e;
    bytes_seen++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected response byte: expected none, actual 0x%0h last=%0b",
               $time, d[7:0], last);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    compare("resp_byte", e.data, d[7:0]);
    compare("last_byte", e.last, last);
    compare("enable_strobe", e.en_strobe, d[8]);
    compare("enable_value", e.en_value, d[9]);
    compare("estop_strobe", e.estop, d[10]);
    compare("direction_reverse", e.dir, d[11]);
    compare("speed_setpoint", e.speed, d[21:12]);
    compare("accel_rate", e.accel, d[31:22]);
    compare("decel_rate", e.decel, d[41:32]);
  endfunction
endclass

module testbench;

  localparam int          RandomItems = 460;
  localparam int          HoldCycles  = 300;
  localparam int          DrainCycles = 30;
  localparam int unsigned CycleLimit  = 200000;
  // Function codes outside the served set
  localparam logic [7:0]  FcZero      = 8'h00;
  localparam logic [7:0]  FcTop       = 8'hFF;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  bit                  calm         = 1'b0;
  bit                  hold_request = 1'b0;
  int                  hold_left    = 0;
  int unsigned         cycle_count  = 0;
  mb_response_board    sb = new();

  modbus_pdu_responder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d bytes still expected", $time, sb.pending());
      $display("[modbus_pdu_responder] ERROR");
      $finish;
    end
  end

  function automatic logic [InDataW-1:0] pack_request(mb_request_t r);
    return {5'd0, r.uptime, r.cur_speed, r.rail_mv, r.fwd, r.en, r.wifi,
            r.len, r.qv, r.addr, r.fc};
  endfunction

  // Build a request with random live status
  function automatic mb_request_t make_req(logic [7:0] fc, logic [15:0] addr,
                                           logic [15:0] qv, logic [7:0] len);
    mb_request_t r;
    r.fc        = fc;
    r.addr      = addr;
    r.qv        = qv;
    r.len       = len;
    r.wifi      = 1'($urandom_range(0, 1));
    r.en        = 1'($urandom_range(0, 1));
    r.fwd       = 1'($urandom_range(0, 1));
    r.rail_mv   = 16'($urandom);
    r.cur_speed = 16'($urandom);
    r.uptime    = 16'($urandom);
    return r;
  endfunction

  // Mostly well-formed requests with random content, some noise
  function automatic mb_request_t next_random_request();
    mb_request_t r;
    int          sel;
    r   = make_req(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom_range(0, 255)));
    sel = $urandom_range(0, 99);
    if (sel >= 12) begin
      r.len = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 4))
                                           : 8'($urandom_range(5, 255));
      case ($urandom_range(0, 4))
        0: begin
          r.fc   = FcReadCoils;
          r.addr = 16'($urandom_range(0, 1));
          r.qv   = 16'($urandom_range(0, 2));
        end
        1, 2: begin
          r.fc   = ($urandom_range(0, 1) == 0) ? FcReadHolding : FcReadInput;
          r.addr = 16'($urandom_range(0, 3));
          r.qv   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 5))
                                               : 16'($urandom_range(1, 4 - int'(r.addr)));
        end
        3: begin
          r.fc   = FcWriteCoil;
          r.addr = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 3))
                                               : 16'($urandom_range(0, 1));
          sel    = $urandom_range(0, 99);
          if (sel < 45) r.qv = CoilOn;
          else if (sel < 90) r.qv = 16'd0;
        end
        default: begin
          r.fc   = FcWriteReg;
          r.addr = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 5))
                                               : 16'($urandom_range(0, 3));
          if ($urandom_range(0, 9) != 0) begin
            case (r.addr)
              16'd0:   r.qv = 16'($urandom_range(0, 1));
              16'd1:   r.qv = 16'($urandom_range(0, 1000));
              default: r.qv = 16'($urandom_range(1, 1000));
            endcase
          end else if ($urandom_range(0, 1) == 0) begin
            r.qv = 16'($urandom_range(0, 1002));
          end
        end
      endcase
    end
    return r;
  endfunction

  // Offer one request transaction, with an occasional idle gap before it
  task automatic send_request(input mb_request_t r);
    if (!calm && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_request(r);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
  endtask

  // Check output transactions and pace out_tready
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && (calm || $urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    mb_request_t r;

    // Hold reset at the start, then release it
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty, unknown and short requests
    send_request(make_req(FcReadHolding, 16'd0, 16'd4, 8'd0));
    send_request(make_req(FcZero, 16'd0, 16'd1, 8'd5));
    send_request(make_req(FcTop, 16'hFFFF, 16'hFFFF, 8'd1));
    send_request(make_req(FcReadHolding, 16'd0, 16'd1, 8'd4));

    // Directed: coil reads and their address checks, including a 16-bit address wrap
    r    = make_req(FcReadCoils, 16'd0, 16'd2, 8'd5);
    r.en = 1'b1;
    send_request(r);
    send_request(make_req(FcReadCoils, 16'd1, 16'd1, 8'd5));
    send_request(make_req(FcReadCoils, 16'd0, 16'd0, 8'd5));
    send_request(make_req(FcReadCoils, 16'hFFFF, 16'd3, 8'd5));

    // Directed: register reads at the status extremes
    send_request(make_req(FcReadHolding, 16'd0, 16'd4, 8'd5));
    r = make_req(FcReadInput, 16'd0, 16'd4, 8'd255);
    {r.wifi, r.en, r.fwd} = 3'b110;
    {r.rail_mv, r.cur_speed, r.uptime} = '1;
    send_request(r);
    r = make_req(FcReadInput, 16'd0, 16'd4, 8'd5);
    {r.wifi, r.en, r.fwd} = 3'b001;
    {r.rail_mv, r.cur_speed, r.uptime} = '0;
    send_request(r);
    send_request(make_req(FcReadInput, 16'd3, 16'd2, 8'd5));
    send_request(make_req(FcReadHolding, 16'hFFFF, 16'd2, 8'd5));

    // Directed: coil writes, strobes and their exceptions
    send_request(make_req(FcWriteCoil, 16'd0, CoilOn, 8'd5));
    send_request(make_req(FcWriteCoil, 16'd0, 16'd0, 8'd5));
    send_request(make_req(FcWriteCoil, 16'd1, CoilOn, 8'd5));
    send_request(make_req(FcWriteCoil, 16'd1, 16'd0, 8'd5));
    send_request(make_req(FcWriteCoil, 16'd2, CoilOn, 8'd5));
    send_request(make_req(FcWriteCoil, 16'd0, 16'h1234, 8'd5));

    // Directed: register writes at the limits, then read back
    send_request(make_req(FcWriteReg, 16'd0, 16'd1, 8'd5));
    send_request(make_req(FcWriteReg, 16'd1, LimitMax, 8'd5));
    send_request(make_req(FcWriteReg, 16'd1, LimitMax + 16'd1, 8'd5));
    send_request(make_req(FcWriteReg, 16'd2, 16'd0, 8'd5));
    send_request(make_req(FcWriteReg, 16'd3, LimitMax, 8'd5));
    send_request(make_req(FcWriteReg, 16'd2, 16'd1, 8'd5));
    send_request(make_req(FcWriteReg, 16'd4, 16'd5, 8'd5));
    send_request(make_req(FcReadHolding, 16'd0, 16'd4, 8'd5));

    // Pause the sender until the directed responses have drained
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    // Random traffic with one long receiver hold-off and one calm stretch
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 120) hold_request = 1'b1;
      calm = (n >= 260 && n < 340);
      send_request(next_random_request());
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    // Drain and watch for stray bytes
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d requests (%0d exceptions, %0d empty), %0d response bytes checked",
             sb.requests, sb.exceptions, sb.empties, sb.bytes_seen);
    $display("with all function codes, range and value checks, strobes and a long back-pressure");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[modbus_pdu_responder] OK");
    end else begin
      $display("[modbus_pdu_responder] ERROR");
    end
    $finish;
  end

endmodule

[modbus_pdu_responder.f]
design/mpr_pkg.sv
design/mpr_ctrl.sv
design/mpr_datapath.sv
design/modbus_pdu_responder.sv
design/mpr_checker.sv
tb/sv/testbench.sv
